/* hw/rtl/rpmfp_pkg.sv */
// Shared types and constants for the period-to-rpm slew filter.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
package rpmfp_pkg;

  localparam logic [31:0] TimeoutMinUs = 32'd250000;
  localparam logic [31:0] TimeoutMaxUs = 32'd1500000;
  localparam logic [31:0] PeriodLimit  = 32'd5000000;
  localparam logic [31:0] UsPerMinute  = 32'd60000000;
  localparam logic [13:0] RpmLimit     = 14'd12000;
  localparam logic [7:0]  MissMax      = 8'd255;
  localparam logic [13:0] SlewMargin   = 14'd30;

  // Dividend bits actually used by the serial divider
  localparam int DivBits = $clog2(UsPerMinute + 1);
  localparam int DivCntW = $clog2(DivBits);

  typedef struct packed {
    logic load_in;
    logic eval;
    logic check;
    logic div_start;
    logic div_step;
    logic filt;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic timed;
    logic period_zero;
  } stat_t;

endpackage

/* hw/rtl/rpmfp_in_if.sv */
// Request channel: one speed update (time, period, pulse timestamp).
// Depends on nothing.
interface rpmfp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  logic [31:0] rev_period_us;
  logic [31:0] last_pulse_us;

  modport source (output valid, output now_us, output rev_period_us,
                  output last_pulse_us, input ready);
  modport sink (input valid, input now_us, input rev_period_us,
                input last_pulse_us, output ready);
endinterface

/* hw/rtl/rpmfp_out_if.sv */
// Result channel: reported rpm and the timeout flag.
// Depends on nothing.
interface rpmfp_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] rpm_out;
  logic        timed_out;

  modport source (output valid, output rpm_out, output timed_out, input ready);
  modport sink (input valid, input rpm_out, input timed_out, output ready);
endinterface

/* hw/rtl/rpmfp_ctrl.sv */
// Sequencer for the rpm filter: steps the datapath through one request.
// Depends on rpmfp_pkg.
module rpmfp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rpmfp_pkg::stat_t stat,
  output rpmfp_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FILT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                        state, state_next;
  logic [rpmfp_pkg::DivCntW-1:0] cnt, cnt_next;
  logic                          out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        if (stat.timed || stat.period_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == rpmfp_pkg::DivCntW'(rpmfp_pkg::DivBits - 1)) begin
          state_next = S_FILT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FILT: begin
        cmd.filt   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/rpmfp_dp.sv */
// Datapath: request registers, stall check, serial divider, slew filter,
// output register. Depends on rpmfp_pkg; driven by rpmfp_ctrl.
module rpmfp_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic [31:0]      now_us,
  input  logic [31:0]      rev_period_us,
  input  logic [31:0]      last_pulse_us,
  input  rpmfp_pkg::cmd_t  cmd,
  output rpmfp_pkg::stat_t stat,
  output logic [13:0]      rpm_out,
  output logic             timed_out
);

  localparam int QW = rpmfp_pkg::DivBits;

  logic        cam_wheel;
  logic [31:0] now_q, period_q, pulse_q;
  logic [13:0] filtered_rpm, reported_rpm;
  logic [22:0] held_period;
  logic [31:0] seen_pulse_time;
  logic [7:0]  miss_count;
  logic        timed_q;

  logic [QW-1:0] num, quo, rem;
  logic [QW:0]   trial;
  logic          fits;

  logic [31:0] timeout, gap;
  logic [23:0] dbl;
  logic [7:0]  miss_inc;

  logic [QW:0]         rpm_full;
  logic                rpm_ok;
  logic [13:0]         rpm14, lim, f_next;
  logic signed [17:0]  diff, lim_s, dcl, d5;

  // timeout from the held period, then the wrap-safe gap compare
  always_comb begin
    dbl = {held_period, 1'b0};
    if (held_period == '0) begin
      timeout = rpmfp_pkg::TimeoutMinUs;
    end else if ({8'd0, dbl} < rpmfp_pkg::TimeoutMinUs) begin
      timeout = rpmfp_pkg::TimeoutMinUs;
    end else if ({8'd0, dbl} > rpmfp_pkg::TimeoutMaxUs) begin
      timeout = rpmfp_pkg::TimeoutMaxUs;
    end else begin
      timeout = {8'd0, dbl};
    end
    gap      = now_q - pulse_q;
    miss_inc = (miss_count < rpmfp_pkg::MissMax) ? miss_count + 8'd1 : miss_count;
  end

  assign stat.timed       = gap > timeout;
  assign stat.period_zero = period_q == '0;

  // one restoring divide step
  assign trial = {rem, num[QW-1]};
  assign fits  = {{(32-QW-1){1'b0}}, trial} >= period_q;

  // slew-limited filter update
  always_comb begin
    rpm_full = cam_wheel ? {quo, 1'b0} : {1'b0, quo};
    rpm_ok   = (rpm_full != '0) && (rpm_full < (QW+1)'(rpmfp_pkg::RpmLimit));
    rpm14    = rpm_full[13:0];
    lim      = {2'd0, filtered_rpm[13:2]} + {3'd0, filtered_rpm[13:3]}
               + rpmfp_pkg::SlewMargin;
    lim_s    = $signed({4'd0, lim});
    diff     = $signed({4'd0, rpm14}) - $signed({4'd0, filtered_rpm});
    if (diff > lim_s) begin
      dcl = lim_s;
    end else if (diff < -lim_s) begin
      dcl = -lim_s;
    end else begin
      dcl = diff;
    end
    d5 = (dcl <<< 2) + dcl;
    if (filtered_rpm == '0) begin
      f_next = rpm14;
    end else begin
      f_next = filtered_rpm + 14'(d5 >>> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_wheel       <= 1'b0;
      filtered_rpm    <= '0;
      reported_rpm    <= '0;
      held_period     <= '0;
      seen_pulse_time <= '0;
      miss_count      <= '0;
    end else begin
      if (cfg_we) begin
        cam_wheel <= cfg_wdata;
      end
      if (cmd.eval) begin
        if (pulse_q != seen_pulse_time) begin
          seen_pulse_time <= pulse_q;
          miss_count      <= '0;
        end
        if (period_q != '0 && period_q < rpmfp_pkg::PeriodLimit) begin
          held_period <= period_q[22:0];
        end
      end
      if (cmd.check) begin
        if (stat.timed) begin
          miss_count <= miss_inc;
          // drop the speed from the second consecutive miss on
          if (miss_inc >= 8'd2) begin
            filtered_rpm <= '0;
            reported_rpm <= '0;
          end
        end else begin
          miss_count <= '0;
        end
      end
      if (cmd.filt && rpm_ok) begin
        filtered_rpm <= f_next;
        reported_rpm <= f_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_q    <= now_us;
      period_q <= rev_period_us;
      pulse_q  <= last_pulse_us;
    end
    if (cmd.check) begin
      timed_q <= stat.timed;
    end
    if (cmd.div_start) begin
      num <= rpmfp_pkg::UsPerMinute[QW-1:0];
      quo <= '0;
      rem <= '0;
    end else if (cmd.div_step) begin
      num <= {num[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], fits};
      rem <= fits ? QW'({{(32-QW-1){1'b0}}, trial} - period_q) : trial[QW-1:0];
    end
    if (cmd.out_load) begin
      rpm_out   <= reported_rpm;
      timed_out <= timed_q;
    end
  end

endmodule

/* hw/rtl/rpm_from_period_slew_filter_core.sv */
// Engine speed from revolution period with stall detection and slew filter.
// A timeout or zero period goes from the check step straight to the output;
// otherwise the 26-step serial divide (one quotient bit a cycle) and the filter run first.
// One request is handled at a time; the next request is taken once
// the result sits in the output register. Reset (rst, synchronous) clears
// all speed state, the cam_wheel register and the output valid.
module rpm_from_period_slew_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rpmfp_in_if.sink    in_req,
  rpmfp_out_if.source out_res
);

  rpmfp_pkg::cmd_t  cmd;
  rpmfp_pkg::stat_t stat;

  rpmfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpmfp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .now_us        (in_req.now_us),
    .rev_period_us (in_req.rev_period_us),
    .last_pulse_us (in_req.last_pulse_us),
    .cmd           (cmd),
    .stat          (stat),
    .rpm_out       (out_res.rpm_out),
    .timed_out     (out_res.timed_out)
  );

endmodule

/* hw/rtl/rpmfp_checker.sv */
// Port-level checks for the rpm filter core, bound to the top level.
// Depends only on the top level's ports.
module rpmfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] rpm_out,
  input logic        timed_out
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_rpm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rpm_out < 14'd12000))
    else $error("rpm out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(rpm_out) && $stable(timed_out)))
    else $error("stalled result changed");

endmodule

bind rpm_from_period_slew_filter_core rpmfp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .rpm_out   (out_res.rpm_out),
  .timed_out (out_res.timed_out)
);
